// ===== src/gb5_pkg.sv =====
// gb5_pkg: shared types, sizes and constants for the 5x5 Gaussian blur.
// No dependencies; the interfaces, gb5_filter and gaussian_blur_5x5 use it.
`default_nettype none

package gb5_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int CFG_W        = 11;
  localparam int SIZE_W       = CFG_W + 1;
  localparam int PIX_W        = 8;
  localparam int WIN          = 5;
  localparam int LINES        = WIN - 1;
  localparam int MIN_SIZE     = WIN;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Normalization: divide by 273 through a reciprocal and one correction step
  localparam int DIVISOR     = 273;
  localparam int SAT_MAX     = 255;
  localparam int RSUM_W      = 15;
  localparam int SUM_W       = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DIVISOR;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PIX_W + 1;

  typedef logic [PIX_W-1:0]              pixel_t;
  typedef pixel_t [WIN-1:0][WIN-1:0]     window_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef logic [CFG_W-1:0]              cfg_t;
  typedef logic [SIZE_W-1:0]             size_t;
  typedef logic [LINES*PIX_W-1:0]        line_word_t;
  typedef logic [RSUM_W-1:0]             rsum_t;
  typedef logic [SUM_W-1:0]              sum_t;
  typedef logic [RECIP_W-1:0]            recip_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [QUOT_W-1:0]             quot_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Window hand-off from the line buffer to the filter datapath
  typedef struct packed {
    logic valid;
    logic last;
  } win_req_t;

  // Kernel weights, row by row (sum 273)
  localparam logic [5:0] KERNEL [WIN][WIN] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

endpackage

`default_nettype wire

// ===== src/gb5_if.sv =====
// gb5_if: valid/ready stream interfaces for pixel requests and blurred results.
// Depends on gb5_pkg for the pixel type.
`default_nettype none

interface gb5_in_if;
  logic            valid;
  logic            ready;
  gb5_pkg::pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gb5_out_if;
  logic            valid;
  logic            ready;
  gb5_pkg::pixel_t blurred_pixel;
  logic            frame_done;

  modport source (output valid, output blurred_pixel, output frame_done, input ready);
  modport sink   (input valid, input blurred_pixel, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/gb5_filter.sv =====
// gb5_filter: weighted 5x5 sum, divide by 273 and saturate, as an elastic pipeline.
// Depends on gb5_pkg and gb5_out_if.
`default_nettype none

module gb5_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  gb5_pkg::window_t  win_i,
  input  gb5_pkg::win_req_t win_req,
  output logic              win_ready,
  gb5_out_if.source         out_chan
);

  gb5_pkg::rsum_t rsum_c [gb5_pkg::WIN];
  gb5_pkg::rsum_t rsum_r [gb5_pkg::WIN];
  gb5_pkg::sum_t  sum4_c;
  gb5_pkg::sum_t  sum4_r;
  gb5_pkg::sum_t  sum5_r;
  gb5_pkg::prod_t prod5_r;
  gb5_pkg::sum_t  sum6_r;
  gb5_pkg::quot_t q0_6_r;
  gb5_pkg::sum_t  rem_c;
  gb5_pkg::quot_t q_c;
  gb5_pkg::pixel_t out_px_r;
  logic v3_r, v4_r, v5_r, v6_r, out_v_r;
  logic l3_r, l4_r, l5_r, l6_r, out_l_r;
  logic rdy3, rdy4, rdy5, rdy6, go_out;

  // Stage ready chain: a stage takes a request when empty or emptying
  assign go_out    = !out_v_r || out_chan.ready;
  assign rdy6      = !v6_r || go_out;
  assign rdy5      = !v5_r || rdy6;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign win_ready = rdy3;

  // Weight each window row
  always_comb begin
    for (int r = 0; r < gb5_pkg::WIN; r++) begin
      rsum_c[r] = '0;
      for (int c = 0; c < gb5_pkg::WIN; c++) begin
        rsum_c[r] = rsum_c[r] + gb5_pkg::rsum_t'(gb5_pkg::KERNEL[r][c])
                              * gb5_pkg::rsum_t'(win_i[r][c]);
      end
    end
  end

  // Add the row sums
  always_comb begin
    sum4_c = '0;
    for (int r = 0; r < gb5_pkg::WIN; r++) begin
      sum4_c = sum4_c + gb5_pkg::sum_t'(rsum_r[r]);
    end
  end

  // Correct the reciprocal estimate by at most one; the output stage saturates
  always_comb begin
    rem_c = sum6_r - gb5_pkg::sum_t'(q0_6_r) * gb5_pkg::sum_t'(gb5_pkg::DIVISOR);
    q_c   = (rem_c >= gb5_pkg::sum_t'(gb5_pkg::DIVISOR)) ? q0_6_r + 1'b1 : q0_6_r;
  end

  // Valid and last flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy3)   v3_r    <= win_req.valid;
      if (rdy4)   v4_r    <= v3_r;
      if (rdy5)   v5_r    <= v4_r;
      if (rdy6)   v6_r    <= v5_r;
      if (go_out) out_v_r <= v6_r;
    end
  end

  // Payload: row sums, total, reciprocal product, estimate, result
  always_ff @(posedge clk) begin
    if (rdy3 && win_req.valid) begin
      rsum_r <= rsum_c;
      l3_r   <= win_req.last;
    end
    if (rdy4 && v3_r) begin
      sum4_r <= sum4_c;
      l4_r   <= l3_r;
    end
    if (rdy5 && v4_r) begin
      sum5_r  <= sum4_r;
      prod5_r <= gb5_pkg::prod_t'(sum4_r) * gb5_pkg::prod_t'(gb5_pkg::recip_t'(gb5_pkg::RECIP));
      l5_r    <= l4_r;
    end
    if (rdy6 && v5_r) begin
      sum6_r <= sum5_r;
      q0_6_r <= prod5_r[gb5_pkg::RECIP_SHIFT +: gb5_pkg::QUOT_W];
      l6_r   <= l5_r;
    end
    if (go_out && v6_r) begin
      out_px_r <= (q_c > gb5_pkg::quot_t'(gb5_pkg::SAT_MAX)) ?
                  gb5_pkg::pixel_t'(gb5_pkg::SAT_MAX) : q_c[gb5_pkg::PIX_W-1:0];
      out_l_r  <= l6_r;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.blurred_pixel = out_px_r;
  assign out_chan.frame_done    = out_l_r;

  // Reciprocal estimate is never more than one below the quotient
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (rem_c < gb5_pkg::sum_t'(2 * gb5_pkg::DIVISOR)))
    else $error("gb5_filter: quotient correction out of range");

  // Result never needs clipping for an 8-bit window
  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (q_c <= gb5_pkg::quot_t'(gb5_pkg::SAT_MAX)))
    else $error("gb5_filter: quotient above pixel range");

  // Backpressure toward the window only comes when every stage is full
  a_win_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !win_ready |-> (v3_r && v4_r && v5_r && v6_r && out_v_r))
    else $error("gb5_filter: window stalled with a free stage");

endmodule

`default_nettype wire

// ===== src/gaussian_blur_5x5.sv =====
// gaussian_blur_5x5: streaming 5x5 Gaussian blur; line memory, window and counters.
// Depends on gb5_pkg, gb5_if (gb5_in_if, gb5_out_if) and gb5_filter.
//
//   channel    dir  payload                        handshake
//   in_chan    in   pixel_in[7:0]                  valid/ready
//   out_chan   out  blurred_pixel[7:0], frame_done valid/ready
//   cfg_*      in   cfg_idx, cfg_data[10:0]         cfg_we, no stall
//
// Throughput is one pixel per clock unless out_chan stalls: each pixel does one
// line memory read at its column when taken and one write-back as it enters
// the window. A result goes through the read stage, window and filter stages.
// Reset sets the frame to 640x480 and clears the counters; the line memory
// is not cleared. A stalled output fills the five filter stages, the window
// and the read stage before in_chan.ready drops.
`default_nettype none

module gaussian_blur_5x5 (
  input  logic                clk,
  input  logic                rst_n,
  gb5_in_if.sink              in_chan,
  gb5_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  gb5_pkg::cfg_t       cfg_data
);

  gb5_pkg::cfg_t      width_r, height_r;
  gb5_pkg::size_t     w_eff, h_eff;
  gb5_pkg::addr_t     col_r, col_nxt;
  gb5_pkg::row_t      row_r, row_nxt;
  logic               in_acc, row_end, frame_end, emit;

  gb5_pkg::line_word_t line_mem [gb5_pkg::MAX_WIDTH];
  gb5_pkg::line_word_t mem_rd_r;

  logic               s1_v_r, s1_emit_r, s1_last_r, s1_go;
  gb5_pkg::pixel_t    s1_px_r;
  gb5_pkg::addr_t     s1_addr_r;
  gb5_pkg::pixel_t    column [gb5_pkg::WIN];

  gb5_pkg::window_t   window_r;
  logic               win_v_r, win_last_r, win_ready;
  gb5_pkg::win_req_t  win_req;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gb5_pkg::cfg_t'(gb5_pkg::RESET_WIDTH);
      height_r <= gb5_pkg::cfg_t'(gb5_pkg::RESET_HEIGHT);
    end else if (cfg_we) begin
      case (gb5_pkg::cfg_reg_t'(cfg_idx))
        gb5_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        gb5_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range
  always_comb begin
    if (width_r < gb5_pkg::cfg_t'(gb5_pkg::MIN_SIZE))
      w_eff = gb5_pkg::size_t'(gb5_pkg::MIN_SIZE);
    else if (gb5_pkg::size_t'(width_r) > gb5_pkg::size_t'(gb5_pkg::MAX_WIDTH))
      w_eff = gb5_pkg::size_t'(gb5_pkg::MAX_WIDTH);
    else
      w_eff = gb5_pkg::size_t'(width_r);
    if (height_r < gb5_pkg::cfg_t'(gb5_pkg::MIN_SIZE))
      h_eff = gb5_pkg::size_t'(gb5_pkg::MIN_SIZE);
    else if (gb5_pkg::size_t'(height_r) > gb5_pkg::size_t'(gb5_pkg::MAX_HEIGHT))
      h_eff = gb5_pkg::size_t'(gb5_pkg::MAX_HEIGHT);
    else
      h_eff = gb5_pkg::size_t'(height_r);
  end

  // Position of the incoming pixel
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign row_end   = (gb5_pkg::size_t'(col_r) + 1'b1) >= w_eff;
  assign frame_end = row_end && ((gb5_pkg::size_t'(row_r) + 1'b1) >= h_eff);
  assign emit      = (col_r >= gb5_pkg::addr_t'(gb5_pkg::LINES)) &&
                     (row_r >= gb5_pkg::row_t'(gb5_pkg::LINES));

  always_comb begin
    col_nxt = row_end ? '0 : col_r + 1'b1;
    row_nxt = frame_end ? '0 : (row_end ? row_r + 1'b1 : row_r);
  end

  // Advance the counters per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read stage: holds the pixel while its column comes out of memory
  assign s1_go         = s1_v_r && (!win_v_r || win_ready);
  assign in_chan.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_chan.pixel_in;
      s1_addr_r <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= frame_end;
    end
  end

  // Line memory: byte 0 is the oldest row; write back shifted down with the new pixel on top.
  // Reads and write-backs of one column are at least five requests apart.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_addr_r] <= {s1_px_r, mem_rd_r[gb5_pkg::LINES*gb5_pkg::PIX_W-1:gb5_pkg::PIX_W]};
    end
    if (in_acc) begin
      mem_rd_r <= line_mem[col_r];
    end
  end

  // Assemble the new window column
  always_comb begin
    for (int r = 0; r < gb5_pkg::LINES; r++) begin
      column[r] = mem_rd_r[r*gb5_pkg::PIX_W +: gb5_pkg::PIX_W];
    end
    column[gb5_pkg::LINES] = s1_px_r;
  end

  // Shift the window left and drop in the new column
  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int r = 0; r < gb5_pkg::WIN; r++) begin
        for (int c = 0; c < gb5_pkg::WIN - 1; c++) begin
          window_r[r][c] <= window_r[r][c+1];
        end
        window_r[r][gb5_pkg::WIN-1] <= column[r];
      end
      win_last_r <= s1_last_r;
    end
  end

  // Window holds a request only for interior pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_v_r <= 1'b0;
    end else if (s1_go) begin
      win_v_r <= s1_emit_r;
    end else if (win_ready) begin
      win_v_r <= 1'b0;
    end
  end

  assign win_req.valid = win_v_r;
  assign win_req.last  = win_last_r;

  gb5_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_i     (window_r),
    .win_req   (win_req),
    .win_ready (win_ready),
    .out_chan  (out_chan)
  );

  // Read and write-back never hit the same column in one cycle
  a_mem_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_go) |-> (col_r != s1_addr_r))
    else $error("gaussian_blur_5x5: line memory read/write collision");

  // Counters start at the frame origin after reset
  a_reset_origin: assert property (@(posedge clk)
    !rst_n |=> (col_r == '0 && row_r == '0))
    else $error("gaussian_blur_5x5: counters not cleared by reset");

  // A row end returns the column to zero
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && row_end) |=> (col_r == '0))
    else $error("gaussian_blur_5x5: column did not wrap at row end");

  // The window only changes hands when the filter can take a pending request
  a_win_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (win_v_r && !win_ready) |=> (win_v_r && $stable(window_r)))
    else $error("gaussian_blur_5x5: pending window overwritten");

endmodule

`default_nettype wire
